>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// Clocked implication forms with an active-low reset that masks them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

    localparam int NUM_TASKS = 8;      // table depth, 1 to 16
    localparam int TIDX_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int OP_W      = 3;
    localparam int ID_W      = 3;
    localparam int PERIOD_W  = 16;
    localparam int DELAY_W   = 8;
    localparam int TICK_W    = 8;
    localparam int MASK_W    = 8;
    localparam int STEP_W    = $clog2(TICK_W);
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_KILL   = 3'd2,
        OP_PAUSE  = 3'd3,
        OP_RESUME = 3'd4
    } t_opcode;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_DIV  = 5'b00100,
        S_EVAL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

>>> hdl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Time-triggered cooperative scheduler: task table, tick counter, fire mask.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one operation selected by tuser: a tick,
// or a create, kill, pause or resume of one task slot. Every request gives
// exactly one result on the master stream: the mask of tasks that fired and
// the tick counter value used for the checks (non-tick requests return a zero
// mask and the current counter). Create, kill, pause, resume and unused codes
// have their result registered on the accepting edge. A tick walks the table
// under a small sequencer that drives one shared restoring divider (one 17-bit
// compare and subtract per cycle, eight steps per remainder of the 8-bit
// counter by the 16-bit period): a task that is not alive, not ready or has a
// zero period is only skipped in the load state, a task that needs the
// remainder goes through load, eight divide steps and evaluate, and the
// result is posted in the done state once the output register is free. The
// slave side is not ready during that walk, nor while a result waits
// unaccepted in the output register.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // task_id[2:0], period[18:3], first_delay[26:19], has_function[27],
    // start_ready[28], zero[31:29]
    input  logic [31:0] s_axis_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fire_mask[7:0], tick_value[15:8]
    output logic [15:0] m_axis_tdata
);

    // Task table and counter
    logic [ptts_pkg::PERIOD_W-1:0] r_period [ptts_pkg::NUM_TASKS];
    logic [ptts_pkg::PERIOD_W-1:0] n_period [ptts_pkg::NUM_TASKS];
    logic [ptts_pkg::DELAY_W-1:0]  r_delay  [ptts_pkg::NUM_TASKS];
    logic [ptts_pkg::DELAY_W-1:0]  n_delay  [ptts_pkg::NUM_TASKS];
    logic [ptts_pkg::NUM_TASKS-1:0] r_alive, n_alive;
    logic [ptts_pkg::NUM_TASKS-1:0] r_ready, n_ready;
    logic [ptts_pkg::TICK_W-1:0]    r_tick, n_tick;

    // Sequencer and shared divider
    ptts_pkg::t_state              r_state, n_state;
    logic [ptts_pkg::TIDX_W-1:0]   r_idx, n_idx;
    logic [ptts_pkg::STEP_W-1:0]   r_step, n_step;
    logic [ptts_pkg::TICK_W-1:0]   r_dvd, n_dvd;
    logic [ptts_pkg::PERIOD_W-1:0] r_div, n_div;
    logic [ptts_pkg::PERIOD_W-1:0] r_rem, n_rem;
    logic [ptts_pkg::MASK_W-1:0]   r_mask, n_mask;

    // Output register
    logic                          r_out_valid, n_out_valid;
    logic [ptts_pkg::MASK_W-1:0]   r_out_mask, n_out_mask;
    logic [ptts_pkg::TICK_W-1:0]   r_out_tick, n_out_tick;

    // Request fields
    ptts_pkg::t_opcode             req_op;
    logic [ptts_pkg::ID_W-1:0]     req_id;
    logic [ptts_pkg::PERIOD_W-1:0] req_period;
    logic [ptts_pkg::DELAY_W-1:0]  req_delay;
    logic                          req_fn;
    logic                          req_rdy;
    logic [ptts_pkg::TIDX_W-1:0]   req_slot;
    logic                          slot_ok;

    logic                          out_free;
    logic                          req_fire;
    logic                          last_task;
    logic                          eligible;
    logic [ptts_pkg::PERIOD_W:0]   trial;
    logic [ptts_pkg::PERIOD_W:0]   diff;

    assign req_op     = ptts_pkg::t_opcode'(s_axis_tuser);
    assign req_id     = s_axis_tdata[2:0];
    assign req_period = s_axis_tdata[18:3];
    assign req_delay  = s_axis_tdata[26:19];
    assign req_fn     = s_axis_tdata[27];
    assign req_rdy    = s_axis_tdata[28];
    assign req_slot   = ptts_pkg::TIDX_W'(req_id);
    assign slot_ok    = (int'(req_id) < ptts_pkg::NUM_TASKS);

    // The output register can take a new result when empty or being drained
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ptts_pkg::S_IDLE) && out_free;
    assign req_fire      = s_axis_tvalid && s_axis_tready;

    assign last_task = (r_idx == ptts_pkg::TIDX_W'(ptts_pkg::NUM_TASKS - 1));
    assign eligible  = r_alive[r_idx] && r_ready[r_idx] && (r_period[r_idx] != '0);

    // One restoring divide step: shift in the next counter bit, subtract if it fits
    assign trial = {r_rem, r_dvd[ptts_pkg::TICK_W-1]};
    assign diff  = trial - {1'b0, r_div};

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_tick, r_out_mask};

    always_comb begin
        n_period    = r_period;
        n_delay     = r_delay;
        n_alive     = r_alive;
        n_ready     = r_ready;
        n_tick      = r_tick;
        n_state     = r_state;
        n_idx       = r_idx;
        n_step      = r_step;
        n_dvd       = r_dvd;
        n_div       = r_div;
        n_rem       = r_rem;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_mask  = r_out_mask;
        n_out_tick  = r_out_tick;

        case (r_state)
            ptts_pkg::S_IDLE: begin
                if (req_fire) begin
                    if (req_op == ptts_pkg::OP_TICK) begin
                        // Start the table walk with an empty mask
                        n_idx   = '0;
                        n_mask  = '0;
                        n_state = ptts_pkg::S_LOAD;
                    end else begin
                        if (slot_ok) begin
                            case (req_op)
                                ptts_pkg::OP_CREATE: begin
                                    n_period[req_slot] = req_period;
                                    n_delay[req_slot]  = req_delay;
                                    n_alive[req_slot]  = req_fn;
                                    n_ready[req_slot]  = req_rdy;
                                end
                                ptts_pkg::OP_KILL:   n_alive[req_slot] = 1'b0;
                                ptts_pkg::OP_PAUSE:  n_ready[req_slot] = 1'b0;
                                ptts_pkg::OP_RESUME: n_ready[req_slot] = 1'b1;
                                default: ;
                            endcase
                        end
                        n_out_valid = 1'b1;
                        n_out_mask  = '0;
                        n_out_tick  = r_tick;
                    end
                end
            end
            ptts_pkg::S_LOAD: begin
                if (eligible) begin
                    n_rem   = '0;
                    n_dvd   = r_tick;
                    n_div   = r_period[r_idx];
                    n_step  = '0;
                    n_state = ptts_pkg::S_DIV;
                end else if (last_task) begin
                    n_state = ptts_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ptts_pkg::S_DIV: begin
                if (!diff[ptts_pkg::PERIOD_W]) begin
                    n_rem = diff[ptts_pkg::PERIOD_W-1:0];
                end else begin
                    n_rem = trial[ptts_pkg::PERIOD_W-1:0];
                end
                n_dvd  = r_dvd << 1;
                n_step = r_step + 1'b1;
                if (r_step == ptts_pkg::STEP_W'(ptts_pkg::TICK_W - 1)) begin
                    n_state = ptts_pkg::S_EVAL;
                end
            end
            ptts_pkg::S_EVAL: begin
                // Due task: fire when its delay is spent, else count the delay down
                if (r_rem == '0) begin
                    if (r_delay[r_idx] == '0) begin
                        n_mask = r_mask | (ptts_pkg::MASK_W'(1) << r_idx);
                    end else begin
                        n_delay[r_idx] = r_delay[r_idx] - 1'b1;
                    end
                end
                if (last_task) begin
                    n_state = ptts_pkg::S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ptts_pkg::S_LOAD;
                end
            end
            ptts_pkg::S_DONE: begin
                // Post the result and advance the counter once per tick
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_mask  = r_mask;
                    n_out_tick  = r_tick;
                    n_tick      = r_tick + 1'b1;
                    n_state     = ptts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptts_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptts_pkg::S_IDLE;
            r_alive     <= '0;
            r_ready     <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_alive     <= n_alive;
            r_ready     <= n_ready;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_step      <= n_step;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_period   <= n_period;
        r_delay    <= n_delay;
        r_dvd      <= n_dvd;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_mask     <= n_mask;
        r_out_mask <= n_out_mask;
        r_out_tick <= n_out_tick;
    end

endmodule

>>> hdl/ptts_checker.sv
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks of the periodic task tick scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic s_fire;
    logic m_stall;
    logic is_tick;

    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign m_stall = m_axis_tvalid && !m_axis_tready;
    assign is_tick = (s_axis_tuser == ptts_pkg::OP_TICK);

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // No request is taken while a result is stuck in the output register
    `ASSERT_SAME(a_no_accept_on_stall, i_clk, i_rst_n, m_stall, !s_axis_tready)

    // A non-tick request answers on the next cycle with an empty mask
    `ASSERT_NEXT(a_cmd_result, i_clk, i_rst_n, s_fire && !is_tick, m_axis_tvalid && (m_axis_tdata[7:0] == 8'd0))

    // A tick occupies the scheduler: no request is taken on the next cycle
    `ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, s_fire && is_tick, !s_axis_tready)

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

>>> dv/tb_periodic_task_tick_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler
// Self-checking bench for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
// Drive tick, create, kill, pause, resume and unused requests on the slave
// stream in random bursts. Track the task table and the tick counter in a
// scoreboard and compare every master-stream result against the predicted
// fire mask and tick value, in order. Stall the master side on a changing
// pattern of its own.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int MAX_ERROR_LINES = 100;

    // One expected result: fire mask and the counter value used by the tick.
    typedef struct packed {
        logic [ptts_pkg::TICK_W-1:0] tick_value;
        logic [ptts_pkg::MASK_W-1:0] fire_mask;
    } t_fire_result;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow task table, tick counter and expected-result queue.
    // ------------------------------------------------------------------------
    class t_fire_scoreboard;
        logic [ptts_pkg::PERIOD_W-1:0] period_tbl [ptts_pkg::NUM_TASKS];
        logic [ptts_pkg::DELAY_W-1:0]  delay_tbl  [ptts_pkg::NUM_TASKS];
        bit                            alive_tbl  [ptts_pkg::NUM_TASKS];
        bit                            ready_tbl  [ptts_pkg::NUM_TASKS];
        logic [ptts_pkg::TICK_W-1:0]   tick_cnt;
        t_fire_result                  exp_fire_q [$];
        int unsigned                   errors;

        function new();
            for (int k = 0; k < ptts_pkg::NUM_TASKS; k++) begin
                period_tbl[k] = '0;
                delay_tbl[k]  = '0;
                alive_tbl[k]  = 1'b0;
                ready_tbl[k]  = 1'b0;
            end
            tick_cnt = '0;
            errors   = 0;
        endfunction

        function int pending();
            return exp_fire_q.size();
        endfunction

        // Apply one accepted request to the shadow state and queue its result.
        function void note_request(logic [ptts_pkg::OP_W-1:0] op,
                                   logic [ptts_pkg::S_DATA_W-1:0] data);
            logic [ptts_pkg::ID_W-1:0]     id;
            logic [ptts_pkg::PERIOD_W-1:0] per;
            logic [ptts_pkg::DELAY_W-1:0]  dly;
            logic                          fn;
            logic                          rdy;
            logic [ptts_pkg::PERIOD_W-1:0] now;
            t_fire_result                  res;
            id  = data[2:0];
            per = data[18:3];
            dly = data[26:19];
            fn  = data[27];
            rdy = data[28];
            now = {{(ptts_pkg::PERIOD_W-ptts_pkg::TICK_W){1'b0}}, tick_cnt};
            res.fire_mask  = '0;
            res.tick_value = tick_cnt;
            if (op == ptts_pkg::OP_TICK) begin
                for (int k = 0; k < ptts_pkg::NUM_TASKS; k++) begin
                    if (alive_tbl[k] && ready_tbl[k] && period_tbl[k] != 0 &&
                        (now % period_tbl[k]) == 0) begin
                        if (delay_tbl[k] == 0) begin
                            // tasks past the mask width run but get no bit
                            if (k < ptts_pkg::MASK_W)
                                res.fire_mask[k] = 1'b1;
                        end else begin
                            delay_tbl[k] = delay_tbl[k] - 1'b1;
                        end
                    end
                end
                tick_cnt = tick_cnt + 1'b1;
            end else if (int'(id) < ptts_pkg::NUM_TASKS) begin
                case (op)
                    ptts_pkg::OP_CREATE: begin
                        period_tbl[id] = per;
                        delay_tbl[id]  = dly;
                        alive_tbl[id]  = fn;
                        ready_tbl[id]  = rdy;
                    end
                    ptts_pkg::OP_KILL:   alive_tbl[id] = 1'b0;
                    ptts_pkg::OP_PAUSE:  ready_tbl[id] = 1'b0;
                    ptts_pkg::OP_RESUME: ready_tbl[id] = 1'b1;
                    default: ;
                endcase
            end
            exp_fire_q.push_back(res);
        endfunction

        // Compare one accepted result against the oldest expectation.
        function void check_fire(logic [ptts_pkg::M_DATA_W-1:0] data);
            t_fire_result exp_res;
            if (exp_fire_q.size() == 0) begin
                errors++;
                if (errors <= MAX_ERROR_LINES)
                    $display("%0t ERROR unexpected result: expected none, actual %04h",
                             $time, data);
                return;
            end
            exp_res = exp_fire_q.pop_front();
            if (data[7:0] !== exp_res.fire_mask) begin
                errors++;
                if (errors <= MAX_ERROR_LINES)
                    $display("%0t ERROR fire_mask: expected %02h, actual %02h",
                             $time, exp_res.fire_mask, data[7:0]);
            end
            if (data[15:8] !== exp_res.tick_value) begin
                errors++;
                if (errors <= MAX_ERROR_LINES)
                    $display("%0t ERROR tick_value: expected %02h, actual %02h",
                             $time, exp_res.tick_value, data[15:8]);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals; every block input starts at a known value.
    // ------------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // task_id, period, first_delay, has_function, start_ready, zero
    logic [ptts_pkg::S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [ptts_pkg::OP_W-1:0]       s_axis_tuser  = '0;   // opcode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ptts_pkg::M_DATA_W-1:0]   m_axis_tdata;         // fire_mask, tick_value

    t_fire_scoreboard fire_sb = new();

    periodic_task_tick_scheduler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: check results first, then log the request accepted at the
    // same edge (its result can only appear on a later edge).
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                fire_sb.check_fire(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                fire_sb.note_request(s_axis_tuser, s_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switch to a new stall pattern whenever a random countdown runs out.
    // Modes: always ready, coin flip, mostly stalled, square wave.
    // ------------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    int unsigned stall_cyc  = 0;

    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 400);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= stall_cyc[3];
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender tasks; each is entered and left on a rising edge.
    // ------------------------------------------------------------------------
    function automatic logic [ptts_pkg::S_DATA_W-1:0] pack_request(
        logic [ptts_pkg::ID_W-1:0] id, logic [ptts_pkg::PERIOD_W-1:0] per,
        logic [ptts_pkg::DELAY_W-1:0] dly, logic fn, logic rdy);
        return {3'b000, rdy, fn, dly, per, id};
    endfunction

    // Present one request and hold it until the handshake.
    task automatic send_request(logic [ptts_pkg::OP_W-1:0] op,
                                logic [ptts_pkg::S_DATA_W-1:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic idle_gap(int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off until every queued result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (fire_sb.pending() != 0);
    endtask

    // One random request, weighted toward ticks and small periods so
    // tasks actually come due, count down and fire.
    task automatic send_random_request();
        int unsigned               pick;
        logic [ptts_pkg::OP_W-1:0] op;
        logic [15:0]               per;
        logic [7:0]                dly;
        pick = $urandom_range(0, 99);
        if (pick < 55)      op = ptts_pkg::OP_TICK;
        else if (pick < 72) op = ptts_pkg::OP_CREATE;
        else if (pick < 80) op = ptts_pkg::OP_KILL;
        else if (pick < 88) op = ptts_pkg::OP_PAUSE;
        else if (pick < 98) op = ptts_pkg::OP_RESUME;
        else                op = ptts_pkg::OP_W'($urandom_range(5, 7));   // unused codes
        pick = $urandom_range(0, 99);
        if (pick < 70)      per = 16'($urandom_range(1, 8));
        else if (pick < 85) per = 16'($urandom_range(9, 300));
        else if (pick < 92) per = '0;
        else                per = 16'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 60)      dly = 8'($urandom_range(0, 3));
        else if (pick < 90) dly = 8'($urandom_range(4, 20));
        else                dly = 8'($urandom());
        send_request(op, pack_request(ptts_pkg::ID_W'($urandom_range(0, 7)), per, dly,
                                      ($urandom_range(0, 9) != 0),
                                      ($urandom_range(0, 4) != 0)));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned burst_left;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: tick on an empty table, resume of a never-created slot
        send_request(ptts_pkg::OP_TICK,   '0);
        send_request(ptts_pkg::OP_RESUME, pack_request(3'd3, '0, '0, 1'b0, 1'b0));
        // period 1 fires every tick; period 2 with a first delay
        send_request(ptts_pkg::OP_CREATE, pack_request(3'd0, 16'd1, 8'd0, 1'b1, 1'b1));
        send_request(ptts_pkg::OP_CREATE, pack_request(3'd1, 16'd2, 8'd2, 1'b1, 1'b1));
        // zero period: never due, delay stays put
        send_request(ptts_pkg::OP_CREATE, pack_request(3'd2, 16'd0, 8'd5, 1'b1, 1'b1));
        // period above the counter: due only when the counter is zero
        send_request(ptts_pkg::OP_CREATE, pack_request(3'd3, 16'hFFFF, 8'd0, 1'b1, 1'b1));
        // no body, so never alive
        send_request(ptts_pkg::OP_CREATE, pack_request(3'd4, 16'd3, 8'hFF, 1'b0, 1'b1));
        // created suspended
        send_request(ptts_pkg::OP_CREATE, pack_request(3'd5, 16'd300, 8'd1, 1'b1, 1'b0));
        send_request(ptts_pkg::OP_CREATE, pack_request(3'd7, 16'd255, 8'd0, 1'b1, 1'b1));
        repeat (3) send_request(ptts_pkg::OP_TICK, '0);
        send_request(ptts_pkg::OP_PAUSE,  pack_request(3'd0, '0, '0, 1'b0, 1'b0));
        send_request(ptts_pkg::OP_TICK,   '0);
        send_request(ptts_pkg::OP_RESUME, pack_request(3'd0, '0, '0, 1'b0, 1'b0));
        send_request(ptts_pkg::OP_RESUME, pack_request(3'd5, '0, '0, 1'b0, 1'b0));
        send_request(ptts_pkg::OP_KILL,   pack_request(3'd1, '0, '0, 1'b0, 1'b0));
        send_request(ptts_pkg::OP_TICK,   '0);
        // unused codes with all-ones payload must leave slot 7 alone
        send_request(3'd5, pack_request(3'd7, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
        send_request(3'd6, pack_request(3'd7, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
        send_request(3'd7, pack_request(3'd7, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
        send_request(ptts_pkg::OP_TICK,   '0);
        send_request(ptts_pkg::OP_CREATE, pack_request(3'd6, 16'd1, 8'hFF, 1'b1, 1'b1));
        send_request(ptts_pkg::OP_TICK,   '0);
        drain_results();

        // Random bursts; the counter wraps several times over this run.
        burst_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0)
                    idle_gap($urandom_range(1, 12));
                burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 10);
            end
            send_random_request();
            burst_left--;
            if (n == RANDOM_REQUESTS / 3 || n == 2 * RANDOM_REQUESTS / 3)
                drain_results();
        end

        // Wait out the last results, then watch for stray ones.
        drain_results();
        repeat (200) @(posedge i_clk);

        if (fire_sb.errors == 0 && fire_sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
